/* rtl/bds_pkg.sv */
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and constants for the 2x2 box-filter downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bds_pkg;

  // Channel layout of one pixel word.
  localparam int ChanW   = 8;
  localparam int NumChan = 4;
  localparam int PairW   = ChanW + 1;   // sum of two samples
  localparam int QuadW   = ChanW + 2;   // sum of four samples
  localparam int LineW   = NumChan * PairW;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;
  localparam int FmtW     = 2;

  // Geometry limits.
  localparam int DefMaxWidth = 4096;
  localparam int MaxHeight   = 4096;
  localparam int RowW        = 12;

  // Register reset values.
  localparam logic [CfgDataW-1:0] WidthRst  = CfgDataW'(640);
  localparam logic [CfgDataW-1:0] HeightRst = CfgDataW'(480);

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PIXEL_FORMAT = 2'd2
  } cfg_reg_e;

  typedef enum logic [FmtW-1:0] {
    FMT_GRAY = 2'd0,
    FMT_RGB  = 2'd1,
    FMT_RGBA = 2'd2
  } pix_fmt_e;

  typedef logic [NumChan-1:0][ChanW-1:0] pix_t;
  typedef logic [NumChan-1:0][PairW-1:0] pair_t;

endpackage : bds_pkg

`default_nettype wire

/* rtl/bds_ram.sv */
// ----------------------------------------------------------------------------
// bds_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_ram #(
  parameter int DataW = 36,
  parameter int Depth = 2048,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : bds_ram

`default_nettype wire

/* rtl/box_downsample_2x2.sv */
// ----------------------------------------------------------------------------
// box_downsample_2x2
// 2x2 box-filter downsampler for a raster-order pixel stream.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  --------  ---------  ----------------------  ---------------------------------
//  in        sink       in_valid_i / in_stall_o  chan0_i .. chan3_i
//  out       source     out_valid_o / out_stall_i out0_o .. out3_o, frame_end_o
//  cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  One source pixel is taken per clock unless the input stalls. A result word
//  leaves after the pixel that completes its 2x2 block, passing through the
//  line-store read stage and then the final add into the output register.
//  Throughput is set by the single-port read of the line store; it sustains one
//  pixel per clock with no bubbles while the input is not stalled.
//  Reset clears the counters, the left-sample hold and all valid flags; the line
//  store needs no clearing pass because every odd row reads entries that the
//  preceding even row wrote.
//  The input stalls only when the read stage is full and the output register
//  is full and stalled.
//
`default_nettype none

module box_downsample_2x2 #(
  parameter int MAX_WIDTH = bds_pkg::DefMaxWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Source pixel channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bds_pkg::ChanW-1:0]     chan0_i,
  input  wire logic [bds_pkg::ChanW-1:0]     chan1_i,
  input  wire logic [bds_pkg::ChanW-1:0]     chan2_i,
  input  wire logic [bds_pkg::ChanW-1:0]     chan3_i,
  // Result pixel channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [bds_pkg::ChanW-1:0]     out0_o,
  output logic      [bds_pkg::ChanW-1:0]     out1_o,
  output logic      [bds_pkg::ChanW-1:0]     out2_o,
  output logic      [bds_pkg::ChanW-1:0]     out3_o,
  output logic                               frame_end_o,
  // Configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bds_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bds_pkg::CfgDataW-1:0]  cfg_data_i
);

  import bds_pkg::*;

  // Column counter width, compare width and line store geometry.
  localparam int XW        = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int CmpW      = (WW > CfgDataW) ? WW : CfgDataW;
  localparam int LineDepth = (MAX_WIDTH + 1) / 2;
  localparam int AW        = (LineDepth > 1) ? $clog2(LineDepth) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken at once.
  // --------------------------------------------------------------------------
  logic [CfgDataW-1:0] frame_width_q, frame_height_q;
  logic [FmtW-1:0]     pixel_format_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WidthRst;
      frame_height_q <= HeightRst;
      pixel_format_q <= FMT_RGBA;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        REG_PIXEL_FORMAT: pixel_format_q <= cfg_data_i[FmtW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero counts as one, oversize saturates.
  logic [CmpW-1:0] fw_ext, fh_ext, width_eff, height_eff;

  always_comb begin
    fw_ext = CmpW'(frame_width_q);
    fh_ext = CmpW'(frame_height_q);
    if (fw_ext == '0) begin
      width_eff = CmpW'(1);
    end else if (fw_ext > CmpW'(MAX_WIDTH)) begin
      width_eff = CmpW'(MAX_WIDTH);
    end else begin
      width_eff = fw_ext;
    end
    if (fh_ext == '0) begin
      height_eff = CmpW'(1);
    end else if (fh_ext > CmpW'(MaxHeight)) begin
      height_eff = CmpW'(MaxHeight);
    end else begin
      height_eff = fh_ext;
    end
  end

  // --------------------------------------------------------------------------
  // Handshakes and pipeline control.
  // The read stage (s1) moves into the output register whenever that register
  // is empty or being taken; a new pixel enters unless s1 is full and stuck.
  // --------------------------------------------------------------------------
  logic in_accept;
  logic s1_adv;
  logic s1_valid_q, out_valid_q;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Raster position of the incoming pixel. The counters are corrected first,
  // in case a smaller size was written since the last pixel.
  // --------------------------------------------------------------------------
  logic [XW-1:0]   col_q, col_d, pos_x;
  logic [RowW-1:0] row_q, row_d, pos_y;
  logic [RowW:0]   row_try;
  logic            col_wrap;
  logic [CmpW-1:0] x_next, y_next;

  always_comb begin
    col_wrap = CmpW'(col_q) >= width_eff;
    pos_x    = col_wrap ? '0 : col_q;
    row_try  = col_wrap ? ({1'b0, row_q} + 1'b1) : {1'b0, row_q};
    pos_y    = (CmpW'(row_try) >= height_eff) ? '0 : row_try[RowW-1:0];

    x_next = CmpW'(pos_x) + CmpW'(1);
    y_next = CmpW'(pos_y) + CmpW'(1);
    if (x_next >= width_eff) begin
      col_d = '0;
      row_d = (y_next >= height_eff) ? '0 : y_next[RowW-1:0];
    end else begin
      col_d = x_next[XW-1:0];
      row_d = pos_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Channel masking and horizontal pair sums. The left pixel of a pair is held
  // until its right neighbor arrives.
  // --------------------------------------------------------------------------
  pix_t  cur_pix, hold_q;
  pair_t pair_sum;

  always_comb begin
    cur_pix = '0;
    case (pixel_format_q)
      FMT_GRAY: begin
        cur_pix[0] = chan0_i;
      end
      FMT_RGB: begin
        cur_pix[0] = chan0_i;
        cur_pix[1] = chan1_i;
        cur_pix[2] = chan2_i;
      end
      default: begin
        // RGBA, and the unused code which behaves as RGBA.
        cur_pix[0] = chan0_i;
        cur_pix[1] = chan1_i;
        cur_pix[2] = chan2_i;
        cur_pix[3] = chan3_i;
      end
    endcase
    for (int c = 0; c < NumChan; c++) begin
      pair_sum[c] = {1'b0, hold_q[c]} + {1'b0, cur_pix[c]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
    end else if (in_accept && !pos_x[0]) begin
      hold_q <= cur_pix;
    end
  end

  // --------------------------------------------------------------------------
  // Line store of pair sums. Even rows write at each odd column; odd rows read
  // the same entry back. A write and the read of that entry are always a full
  // row apart, so the registered read needs no forwarding.
  // --------------------------------------------------------------------------
  logic [XW-1:0]    x_half;
  logic [AW-1:0]    line_idx;
  logic             line_we, line_re;
  logic [LineW-1:0] line_rdata;

  assign x_half   = pos_x >> 1;
  assign line_idx = x_half[AW-1:0];
  assign line_we  = in_accept && pos_x[0] && !pos_y[0];
  assign line_re  = in_accept && pos_x[0] && pos_y[0];

  bds_ram #(
    .DataW (LineW),
    .Depth (LineDepth),
    .AddrW (AW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_idx),
    .wdata_i (pair_sum),
    .re_i    (line_re),
    .raddr_i (line_idx),
    .rdata_o (line_rdata)
  );

  // Last block of the frame: bottom-right pixel of the last full 2x2 block.
  logic [CmpW-1:0] x_last, y_last;
  logic            is_last;

  assign x_last  = (width_eff & ~CmpW'(1)) - CmpW'(1);
  assign y_last  = (height_eff & ~CmpW'(1)) - CmpW'(1);
  assign is_last = (CmpW'(pos_x) == x_last) && (CmpW'(pos_y) == y_last);

  // --------------------------------------------------------------------------
  // Read stage: holds the current pair while the stored pair is fetched.
  // --------------------------------------------------------------------------
  pair_t s1_pair_q;
  logic  s1_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= line_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_re) begin
      s1_pair_q <= pair_sum;
      s1_end_q  <= is_last;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: vertical sum of both pairs, divided by four.
  // --------------------------------------------------------------------------
  pair_t                     stored_pair;
  pix_t                      avg_pix, out_pix_q;
  logic [NumChan-1:0][QuadW-1:0] quad_sum;
  logic                      out_end_q;

  assign stored_pair = line_rdata;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      quad_sum[c] = {1'b0, stored_pair[c]} + {1'b0, s1_pair_q[c]};
      avg_pix[c]  = quad_sum[c][QuadW-1:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_pix_q <= avg_pix;
      out_end_q <= s1_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out0_o      = out_pix_q[0];
  assign out1_o      = out_pix_q[1];
  assign out2_o      = out_pix_q[2];
  assign out3_o      = out_pix_q[3];
  assign frame_end_o = out_end_q;

endmodule : box_downsample_2x2

`default_nettype wire

/* rtl/bds_checker.sv */
// ----------------------------------------------------------------------------
// bds_checker
// Port-level checks for the 2x2 box-filter downsampler, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [bds_pkg::ChanW-1:0]     out0_o,
  input wire logic [bds_pkg::ChanW-1:0]     out1_o,
  input wire logic [bds_pkg::ChanW-1:0]     out2_o,
  input wire logic [bds_pkg::ChanW-1:0]     out3_o,
  input wire logic                          frame_end_o
);

  import bds_pkg::*;

  // A stalled result word keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out0_o) && $stable(out1_o)
      && $stable(out2_o) && $stable(out3_o) && $stable(frame_end_o))
    else $error("stalled result word changed");

  // Valid only falls after the word was taken.
  a_out_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped while stalled");

  // The input only backs up when the output side is full and stalled.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A fresh result must trace back to an accepted source pixel.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result appeared without a source pixel");

endmodule : bds_checker

bind box_downsample_2x2 bds_checker u_bds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out0_o      (out0_o),
  .out1_o      (out1_o),
  .out2_o      (out2_o),
  .out3_o      (out3_o),
  .frame_end_o (frame_end_o)
);

`default_nettype wire
